// ===== rtl/rmr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rmr_pkg;

    localparam int BYTE_W      = 8;
    localparam int OFFSET_W    = 18;
    localparam int WORDS_W     = 16;
    localparam int ELEM_W      = 5;
    localparam int KIND_W      = 2;
    localparam int MASK_W      = 15;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;
    localparam int MID_DEPTH   = 2;

    localparam logic [15:0]          PROFILE_ONE_BYTE = 16'hBEDE;
    localparam logic [3:0]           ID_MASK          = 4'hF;
    localparam logic [3:0]           ID_PAD           = 4'h0;
    localparam logic [OFFSET_W-1:0]  REGION_START     = OFFSET_W'(4);
    localparam logic [OFFSET_W-1:0]  OFFSET_MAX       = {OFFSET_W{1'b1}};

    localparam logic [KIND_W-1:0] KIND_VIDEO = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AUDIO = 2'd1;
    localparam logic [KIND_W-1:0] KIND_OTHER = 2'd2;

    localparam logic REG_VIDEO_MASK = 1'b0;
    localparam logic REG_AUDIO_MASK = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              block_start;
        logic [KIND_W-1:0] media_kind;
        logic              last_byte;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              out_last;
    } t_out_word;

    // classified byte handed from parser to output stage
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
        logic              zero;
    } t_mid_word;

endpackage

`default_nettype wire

// ===== rtl/rmr_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmr_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire rmr_pkg::t_in_word            i_in_word,
    input  wire logic [rmr_pkg::MASK_W-1:0]   i_video_mask,
    input  wire logic [rmr_pkg::MASK_W-1:0]   i_audio_mask,
    output rmr_pkg::t_mid_word                o_mid_word
);
    import rmr_pkg::*;

    logic [OFFSET_W-1:0] r_offset, n_offset;
    logic [BYTE_W-1:0]   r_prof_high, n_prof_high;
    logic                r_prof_match, n_prof_match;
    logic [WORDS_W-1:0]  r_words, n_words;
    logic [ELEM_W-1:0]   r_elem_left, n_elem_left;
    logic                r_elem_zero, n_elem_zero;
    logic                r_done, n_done;
    logic [KIND_W-1:0]   r_kind, n_kind;

    logic                zero;

    always_comb begin
        logic [OFFSET_W-1:0] off;
        logic [OFFSET_W-1:0] d;
        logic [3:0]          hdr_id;
        logic [3:0]          hdr_len;
        logic [MASK_W-1:0]   mask;
        logic                strip;

        n_offset     = r_offset;
        n_prof_high  = r_prof_high;
        n_prof_match = r_prof_match;
        n_words      = r_words;
        n_elem_left  = r_elem_left;
        n_elem_zero  = r_elem_zero;
        n_done       = r_done;
        n_kind       = r_kind;
        zero         = 1'b0;

        // a block start clears the per-block state before this byte is parsed
        if (i_in_word.block_start) begin
            n_offset     = '0;
            n_prof_high  = '0;
            n_prof_match = 1'b0;
            n_words      = '0;
            n_elem_left  = '0;
            n_elem_zero  = 1'b0;
            n_done       = 1'b0;
            n_kind       = i_in_word.media_kind;
        end

        off     = n_offset;
        d       = off - REGION_START;
        hdr_id  = i_in_word.data_byte[7:4];
        hdr_len = i_in_word.data_byte[3:0];
        mask    = (n_kind == KIND_VIDEO) ? i_video_mask : i_audio_mask;
        strip   = mask[hdr_id - 4'd1];

        priority if (off == OFFSET_W'(0)) begin
            n_prof_high = i_in_word.data_byte;
        end else if (off == OFFSET_W'(1)) begin
            n_prof_match = ({n_prof_high, i_in_word.data_byte} == PROFILE_ONE_BYTE);
        end else if (off == OFFSET_W'(2)) begin
            n_words = {i_in_word.data_byte, n_words[BYTE_W-1:0]};
            n_words[BYTE_W-1:0] = '0;
        end else if (off == OFFSET_W'(3)) begin
            n_words = {n_words[WORDS_W-1:BYTE_W], i_in_word.data_byte};
        end else begin
            if (n_prof_match && (n_kind < KIND_OTHER) && !n_done
                && (d < {n_words, 2'b00})) begin
                if (n_elem_left != '0) begin
                    zero        = n_elem_zero;
                    n_elem_left = n_elem_left - ELEM_W'(1);
                    if (n_elem_left == '0) begin
                        n_elem_zero = 1'b0;
                    end
                end else if (hdr_id == ID_MASK) begin
                    n_done = 1'b1;
                end else if (hdr_id != ID_PAD) begin
                    n_elem_zero = strip;
                    n_elem_left = ELEM_W'(hdr_len) + ELEM_W'(1);
                    zero        = strip;
                end
            end
        end

        // saturate the offset and stop parsing at the counter's end
        if (off != OFFSET_MAX) begin
            n_offset = off + OFFSET_W'(1);
        end else begin
            n_done      = 1'b1;
            n_elem_left = '0;
            n_elem_zero = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset     <= '0;
            r_prof_high  <= '0;
            r_prof_match <= 1'b0;
            r_words      <= '0;
            r_elem_left  <= '0;
            r_elem_zero  <= 1'b0;
            r_done       <= 1'b0;
            r_kind       <= KIND_OTHER;
        end else if (i_accept) begin
            r_offset     <= n_offset;
            r_prof_high  <= n_prof_high;
            r_prof_match <= n_prof_match;
            r_words      <= n_words;
            r_elem_left  <= n_elem_left;
            r_elem_zero  <= n_elem_zero;
            r_done       <= n_done;
            r_kind       <= n_kind;
        end
    end

    assign o_mid_word.data_byte = i_in_word.data_byte;
    assign o_mid_word.last_byte = i_in_word.last_byte;
    assign o_mid_word.zero      = zero;

endmodule

`default_nettype wire

// ===== rtl/rmr_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmr_fifo #(
    parameter int DEPTH = rmr_pkg::MID_DEPTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr,
    input  wire rmr_pkg::t_mid_word   i_wr_word,
    output logic                      o_full,
    input  wire logic                 i_rd,
    output rmr_pkg::t_mid_word        o_rd_word,
    output logic                      o_valid
);
    import rmr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_mid_word          r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1)) begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_rd) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            unique case ({i_wr, i_rd})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_rd_word = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

// ===== rtl/rmr_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rmr_back (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_mid_valid,
    input  wire rmr_pkg::t_mid_word   i_mid_word,
    output logic                      o_mid_rd,
    input  wire logic                 i_pop,
    output logic                      o_empty,
    output rmr_pkg::t_out_word        o_out_word
);
    import rmr_pkg::*;

    logic      r_valid;
    t_out_word r_word;

    // advance when the output slot is free or being taken
    assign o_mid_rd = i_mid_valid && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_mid_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_rd) begin
            r_word.out_byte <= i_mid_word.zero ? '0 : i_mid_word.data_byte;
            r_word.out_last <= i_mid_word.last_byte;
        end
    end

    assign o_empty    = !r_valid;
    assign o_out_word = r_word;

endmodule

`default_nettype wire

// ===== rtl/rtp_ext_mid_rid_stripper.sv =====
// Data path: a pushed byte is written into the queue, then moved into the output register on the result ports.
// Throughput: one byte per cycle while the queue is not full; the parser state updates once per accepted byte.
// The two-entry queue between parser and output register absorbs result stalls.
// Reset (synchronous, active low): clears masks, parser state, the queue and the output register;
// latched media kind resets to "other".
`timescale 1ns / 1ps
`default_nettype none

module rtp_ext_mid_rid_stripper #(
    parameter int MID_DEPTH = rmr_pkg::MID_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire rmr_pkg::t_in_word             i_in_word,
    output logic                               empty,
    input  wire logic                          pop,
    output rmr_pkg::t_out_word                 o_out_word,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rmr_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [rmr_pkg::PDATA_W-1:0]   pwdata,
    output logic [rmr_pkg::PDATA_W-1:0]        prdata,
    output logic                               pready
);
    import rmr_pkg::*;

    logic [MASK_W-1:0] r_video_mask;
    logic [MASK_W-1:0] r_audio_mask;
    logic              cfg_wr;
    logic              accept;
    t_mid_word         mid_wr_word;
    t_mid_word         mid_rd_word;
    logic              mid_full;
    logic              mid_valid;
    logic              mid_rd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_video_mask <= '0;
            r_audio_mask <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_VIDEO_MASK: r_video_mask <= pwdata[MASK_W-1:0];
                REG_AUDIO_MASK: r_audio_mask <= pwdata[MASK_W-1:0];
                default:        r_video_mask <= r_video_mask;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_VIDEO_MASK: prdata = PDATA_W'(r_video_mask);
            REG_AUDIO_MASK: prdata = PDATA_W'(r_audio_mask);
            default:        prdata = '0;
        endcase
    end

    assign full   = mid_full;
    assign accept = push && !mid_full;

    rmr_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_in_word    (i_in_word),
        .i_video_mask (r_video_mask),
        .i_audio_mask (r_audio_mask),
        .o_mid_word   (mid_wr_word)
    );

    rmr_fifo #(
        .DEPTH (MID_DEPTH)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (accept),
        .i_wr_word (mid_wr_word),
        .o_full    (mid_full),
        .i_rd      (mid_rd),
        .o_rd_word (mid_rd_word),
        .o_valid   (mid_valid)
    );

    rmr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid_word  (mid_rd_word),
        .o_mid_rd    (mid_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ===== tb/tb_rtp_ext_mid_rid_stripper.sv =====
`timescale 1ns / 1ps

module tb_rtp_ext_mid_rid_stripper;

    import rmr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int NOISY_LINES = 100;

    // Expected stripped bytes, computed from every accepted input word
    class strip_scoreboard;
        logic [MASK_W-1:0]   video_mask;
        logic [MASK_W-1:0]   audio_mask;
        logic [OFFSET_W-1:0] offset;
        logic [BYTE_W-1:0]   profile_hi;
        logic                profile_ok;
        logic [WORDS_W-1:0]  words;
        logic [ELEM_W-1:0]   elem_left;
        logic                zeroing;
        logic                parse_done;
        logic [KIND_W-1:0]   kind;
        t_out_word           expected_bytes[$];
        int                  mismatches;

        function new();
            video_mask = '0;
            audio_mask = '0;
            clear_block();
            kind       = KIND_OTHER;
            mismatches = 0;
        endfunction

        function void clear_block();
            offset     = '0;
            profile_hi = '0;
            profile_ok = 1'b0;
            words      = '0;
            elem_left  = '0;
            zeroing    = 1'b0;
            parse_done = 1'b0;
        endfunction

        function void set_mask(logic idx, logic [MASK_W-1:0] value);
            if (idx == REG_VIDEO_MASK) begin
                video_mask = value;
            end else begin
                audio_mask = value;
            end
        endfunction

        function t_out_word strip_byte(t_in_word w);
            t_out_word         r;
            logic [3:0]        id;
            logic [MASK_W-1:0] m;
            int unsigned       d;
            r.out_byte = w.data_byte;
            r.out_last = w.last_byte;
            if (w.block_start) begin
                clear_block();
                kind = w.media_kind;
            end
            case (offset)
                0: profile_hi = w.data_byte;
                1: profile_ok = ({profile_hi, w.data_byte} == PROFILE_ONE_BYTE);
                2: words = {w.data_byte, 8'h00};
                3: words[7:0] = w.data_byte;
                default: begin
                    d = int'(offset) - int'(REGION_START);
                    if (profile_ok && kind < KIND_OTHER && !parse_done
                            && d < int'(words) * 4) begin
                        if (elem_left != 0) begin
                            if (zeroing) r.out_byte = '0;
                            elem_left = elem_left - 1'b1;
                            if (elem_left == 0) zeroing = 1'b0;
                        end else begin
                            id = w.data_byte[7:4];
                            if (id == ID_MASK) begin
                                parse_done = 1'b1;
                            end else if (id != ID_PAD) begin
                                m         = (kind == KIND_VIDEO) ? video_mask : audio_mask;
                                zeroing   = m[id - 1];
                                elem_left = {1'b0, w.data_byte[3:0]} + 5'd1;
                                if (zeroing) r.out_byte = '0;
                            end
                        end
                    end
                end
            endcase
            // saturate the offset and stop parsing at the top
            if (offset != OFFSET_MAX) begin
                offset = offset + 1'b1;
            end else begin
                parse_done = 1'b1;
                elem_left  = '0;
                zeroing    = 1'b0;
            end
            return r;
        endfunction

        function void note_byte(t_in_word w);
            expected_bytes.push_back(strip_byte(w));
        endfunction

        function void check_byte(t_out_word got);
            t_out_word want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= NOISY_LINES)
                    $display("%0t: unexpected byte %02h last %0b", $time,
                             got.out_byte, got.out_last);
                return;
            end
            want = expected_bytes.pop_front();
            if (got.out_byte !== want.out_byte || got.out_last !== want.out_last) begin
                mismatches++;
                if (mismatches <= NOISY_LINES)
                    $display("%0t: byte mismatch: expected %02h last %0b, got %02h last %0b",
                             $time, want.out_byte, want.out_last, got.out_byte, got.out_last);
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    t_in_word             in_word = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    t_out_word            o_out_word;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [PADDR_W-1:0]   paddr = '0;
    logic [PDATA_W-1:0]   pwdata = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    strip_scoreboard board = new();
    int                   send_gap = 0;
    int                   recv_gap = 0;
    int                   quiet_cycles = 0;

    rtp_ext_mid_rid_stripper dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_in_word  (in_word),
        .empty      (empty),
        .pop        (pop),
        .o_out_word (o_out_word),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        pop = ($urandom_range(99) >= recv_gap);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) board.check_byte(o_out_word);
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("tb_rtp_ext_mid_rid_stripper: FAIL");
                $finish;
            end
        end
    end

    // write a mask register, then read it back
    task automatic write_reg(input logic idx, input logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        board.set_mask(idx, value[MASK_W-1:0]);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[MASK_W-1:0] !== value[MASK_W-1:0]) begin
            board.mismatches++;
            $display("%0t: mask readback at %0h: expected %04h, got %04h", $time, paddr,
                     value[MASK_W-1:0], prdata[MASK_W-1:0]);
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push    = 1'b1;
        in_word = w;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        board.note_byte(w);
    endtask

    // media kind matters only on the start byte; scramble it elsewhere
    task automatic send_packet(input logic [7:0] body[$], input logic [KIND_W-1:0] kind,
                               input bit with_start);
        t_in_word w;
        for (int i = 0; i < body.size(); i++) begin
            w.data_byte   = body[i];
            w.block_start = with_start && (i == 0);
            w.media_kind  = (i == 0) ? kind : KIND_W'($urandom);
            w.last_byte   = (i == body.size() - 1);
            send_word(w);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        while (board.expected_bytes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic random_packet(output int count);
        logic [7:0]        body[$];
        logic [KIND_W-1:0] kind;
        int                pick;
        int                words_val;
        int                region;
        int                len;
        pick = $urandom_range(9);
        if (pick < 4) kind = KIND_VIDEO;
        else if (pick < 8) kind = KIND_AUDIO;
        else if (pick == 8) kind = KIND_OTHER;
        else kind = 2'd3;
        words_val = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(6);
        region = (words_val * 4 > 40) ? 40 : words_val * 4;
        if ($urandom_range(7) != 0) begin
            body.push_back(PROFILE_ONE_BYTE[15:8]);
            body.push_back(PROFILE_ONE_BYTE[7:0]);
        end else begin
            body.push_back(($urandom_range(1)) ? PROFILE_ONE_BYTE[15:8] : 8'($urandom));
            body.push_back(8'($urandom));
        end
        body.push_back(8'(words_val >> 8));
        body.push_back(8'(words_val));
        while (body.size() < 4 + region) begin
            pick = $urandom_range(15);
            if (pick == 0) begin
                body.push_back({ID_PAD, 4'($urandom)});
            end else if (pick == 1) begin
                body.push_back({ID_MASK, 4'($urandom)});
            end else begin
                len = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom_range(2);
                body.push_back({4'($urandom_range(1, 14)), 4'(len)});
                repeat (len + 1) body.push_back(8'($urandom));
            end
        end
        repeat ($urandom_range(3)) body.push_back(8'($urandom));
        if ($urandom_range(7) == 0) begin
            len = $urandom_range(1, body.size());
            while (body.size() > len) void'(body.pop_back());
        end
        send_packet(body, kind, $urandom_range(15) != 0);
        count = body.size();
    endtask

    task automatic random_noise(output int count);
        t_in_word w;
        count = $urandom_range(1, 6);
        repeat (count) begin
            w.data_byte   = 8'($urandom);
            w.block_start = ($urandom_range(3) == 0);
            w.media_kind  = KIND_W'($urandom);
            w.last_byte   = 1'($urandom);
            send_word(w);
        end
    endtask

    task automatic random_phase(input int target);
        int sent;
        int n;
        sent = 0;
        while (sent < target) begin
            if ($urandom_range(9) == 0) random_noise(n);
            else random_packet(n);
            sent += n;
        end
    endtask

    task automatic directed();
        logic [7:0] body[$];
        t_in_word   w;
        // bytes before any block start count as a block of kind other
        w = '{data_byte: 8'hFF, block_start: 1'b0, media_kind: 2'd3, last_byte: 1'b0};
        send_word(w);
        w = '{data_byte: 8'h00, block_start: 1'b0, media_kind: KIND_VIDEO, last_byte: 1'b1};
        send_word(w);
        w = '{data_byte: 8'h5A, block_start: 1'b0, media_kind: KIND_AUDIO, last_byte: 1'b0};
        send_word(w);
        // stripped id 1, padding, kept id 2, then id 15 ends parsing
        body = '{8'hBE, 8'hDE, 8'h00, 8'h02, 8'h10, 8'hAA, 8'h00, 8'h21,
                 8'hBB, 8'hCC, 8'hF2, 8'h11};
        send_packet(body, KIND_VIDEO, 1'b1);
        // stripped element crossing the declared end
        body = '{8'hBE, 8'hDE, 8'h00, 8'h01, 8'h23, 8'h01, 8'h02, 8'h03, 8'h04};
        send_packet(body, KIND_AUDIO, 1'b1);
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        write_reg(REG_VIDEO_MASK, 32'h0000_0001);
        write_reg(REG_AUDIO_MASK, 32'h0000_0002);
        send_gap = 11;
        recv_gap = 52;
        directed();
        drain();
        write_reg(REG_VIDEO_MASK, 32'h0000_0000);
        write_reg(REG_AUDIO_MASK, 32'hFFFF_FFFF);
        random_phase(140);
        drain();
        write_reg(REG_VIDEO_MASK, $urandom);
        write_reg(REG_AUDIO_MASK, $urandom);
        send_gap = 52;
        recv_gap = 11;
        random_phase(130);
        drain();
        write_reg(REG_VIDEO_MASK, 32'h0000_7FFF);
        write_reg(REG_AUDIO_MASK, 32'h0000_0000);
        send_gap = 0;
        recv_gap = 0;
        random_phase(130);
        drain();
        if (board.mismatches == 0) begin
            $display("tb_rtp_ext_mid_rid_stripper: PASS");
        end else begin
            $display("tb_rtp_ext_mid_rid_stripper: FAIL");
        end
        $finish;
    end

endmodule
